FILE: rtl/core/lfeg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfeg_pkg
// Shared widths, register indexes, region codes, side-band type and the
// time helpers of the fade envelope gain block.
// ----------------------------------------------------------------------------
package lfeg_pkg;

    localparam int TIME_BITS   = 48;
    localparam int SAMPLE_BITS = 24;
    localparam int LEN_BITS    = 24;
    localparam int FLAG_BITS   = 4;
    localparam int GAIN_BITS   = 17;
    localparam int Q_BITS      = 16;
    localparam int REGION_BITS = 3;

    // internal breakpoint width, room for time plus a full ramp length
    localparam int TW = ((TIME_BITS > LEN_BITS + 2) ? TIME_BITS : LEN_BITS + 2) + 2;
    localparam int NUM_W = LEN_BITS + 1;
    localparam int DIV_STAGES = GAIN_BITS;
    localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;

    localparam int CFG_W = (TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_FADE_START     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FADE_END       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_START   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_END     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FADE_LENGTH    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEFINED_FLAGS  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_PRESENT = 3'd6;

    localparam logic [REGION_BITS-1:0] REGION_BEFORE = 3'd0;
    localparam logic [REGION_BITS-1:0] REGION_UP     = 3'd1;
    localparam logic [REGION_BITS-1:0] REGION_UNITY  = 3'd2;
    localparam logic [REGION_BITS-1:0] REGION_DOWN   = 3'd3;
    localparam logic [REGION_BITS-1:0] REGION_AFTER  = 3'd4;

    localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << Q_BITS);

    localparam logic signed [TW-1:0] BP_LIM = signed'(TW'(64'd1 << 62));

    typedef struct packed {
        logic [REGION_BITS-1:0]        region;
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
    } t_side;

    function automatic logic signed [TW-1:0] ext_time(input logic signed [TIME_BITS-1:0] v);
        return {{(TW-TIME_BITS){v[TIME_BITS-1]}}, v};
    endfunction

    function automatic logic signed [TW-1:0] ext_len(input logic [LEN_BITS-1:0] v);
        return {{(TW-LEN_BITS){1'b0}}, v};
    endfunction

    // breakpoint saturation, only reachable for very wide time words
    function automatic logic signed [TW-1:0] clamp_bp(input logic signed [TW-1:0] a);
        logic signed [TW-1:0] r;
        r = a;
        if (TIME_BITS > 62) begin
            if (a > BP_LIM) begin
                r = BP_LIM;
            end else if (a < -BP_LIM) begin
                r = -BP_LIM;
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/lfeg_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfeg_div_pipe
// Pipelined restoring divider, one quotient bit per stage, giving
// floor(num * 2^16 / len) for num <= len, with side-band data carried along.
// ----------------------------------------------------------------------------
module lfeg_div_pipe
    import lfeg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [LEN_BITS-1:0]  i_len,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic [GAIN_BITS-1:0] o_quot,
    output t_side                o_side
);

    logic                 r_v    [DIV_STAGES];
    logic [LEN_BITS-1:0]  r_rem  [DIV_STAGES];
    logic [GAIN_BITS-1:0] r_q    [DIV_STAGES];
    t_side                r_side [DIV_STAGES];

    logic [NUM_W-1:0]     w_trial [DIV_STAGES];
    logic                 w_bit   [DIV_STAGES];
    logic [LEN_BITS-1:0]  n_rem   [DIV_STAGES];
    logic [GAIN_BITS-1:0] n_q     [DIV_STAGES];
    logic [NUM_W-1:0]     w_len;

    assign w_len = {1'b0, i_len};

    always_comb begin
        w_trial[0] = i_num;
        for (int k = 1; k < DIV_STAGES; k++) begin
            w_trial[k] = {r_rem[k-1], 1'b0};
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            w_bit[k] = (w_trial[k] >= w_len);
            if (w_bit[k]) begin
                n_rem[k] = LEN_BITS'(w_trial[k] - w_len);
            end else begin
                n_rem[k] = w_trial[k][LEN_BITS-1:0];
            end
        end
        n_q[0] = GAIN_BITS'(w_bit[0]);
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_q[k] = {r_q[k-1][GAIN_BITS-2:0], w_bit[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

FILE: rtl/core/linear_fade_envelope_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_fade_envelope_gain
// Scales a stereo frame by a piecewise-linear fade-in / fade-out envelope
// derived from the fade centres, source limits and ramp length.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in        sink       i_valid / o_stall  sample_time, left/right sample
//  out       source     o_valid / i_stall  left/right out, region, gain
//  cfg       sink       i_cfg_we           i_cfg_addr, i_cfg_data
//
//  one frame per cycle sustained while the output is not stalled
//  the gain divider has 17 stages, one quotient bit per stage
//  reset clears the valid bits and all configuration registers to zero
//  an output stall while o_valid is high freezes the whole pipeline; o_stall follows it directly
// ----------------------------------------------------------------------------
module linear_fade_envelope_gain
    import lfeg_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [TIME_BITS-1:0]   i_sample_time,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    output logic [REGION_BITS-1:0]        o_region,
    output logic [GAIN_BITS-1:0]          o_gain
);

    // configuration
    logic signed [TIME_BITS-1:0] r_fade_start;
    logic signed [TIME_BITS-1:0] r_fade_end;
    logic signed [TIME_BITS-1:0] r_source_start;
    logic signed [TIME_BITS-1:0] r_source_end;
    logic [LEN_BITS-1:0]         r_fade_length;
    logic [FLAG_BITS-1:0]        r_flags;
    logic                        r_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_start   <= '0;
            r_fade_end     <= '0;
            r_source_start <= '0;
            r_source_end   <= '0;
            r_fade_length  <= '0;
            r_flags        <= '0;
            r_present      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FADE_START:     r_fade_start   <= i_cfg_data[TIME_BITS-1:0];
                CFG_FADE_END:       r_fade_end     <= i_cfg_data[TIME_BITS-1:0];
                CFG_SOURCE_START:   r_source_start <= i_cfg_data[TIME_BITS-1:0];
                CFG_SOURCE_END:     r_source_end   <= i_cfg_data[TIME_BITS-1:0];
                CFG_FADE_LENGTH:    r_fade_length  <= i_cfg_data[LEN_BITS-1:0];
                CFG_DEFINED_FLAGS:  r_flags        <= i_cfg_data[FLAG_BITS-1:0];
                CFG_SOURCE_PRESENT: r_present      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    logic w_adv;
    logic r_out_v;

    assign w_adv   = !r_out_v || !i_stall;
    assign o_stall = !w_adv;
    assign o_valid = r_out_v;

    logic signed [TW-1:0] w_len;
    logic signed [TW-1:0] w_half;

    assign w_len  = ext_len(r_fade_length);
    assign w_half = ext_len(r_fade_length >> 1);

    // stage 1: start and end breakpoints
    logic signed [TW-1:0] n_a_s, n_b_s, n_a_e, n_b_e, n_t1, n_t4;
    logic                 n_sf, n_ef;

    always_comb begin
        n_a_s = clamp_bp(clamp_bp(ext_time(r_fade_start)) - w_half);
        n_b_s = clamp_bp(ext_time(r_source_start));
        n_a_e = clamp_bp(clamp_bp(ext_time(r_fade_end)) + w_half);
        n_b_e = clamp_bp(ext_time(r_source_end));
        if (!r_flags[0]) begin
            n_t1 = n_b_s;
        end else if (!r_flags[2]) begin
            n_t1 = n_a_s;
        end else begin
            n_t1 = (n_b_s > n_a_s) ? n_b_s : n_a_s;
        end
        if (!r_flags[1]) begin
            n_t4 = n_b_e;
        end else if (!r_flags[3]) begin
            n_t4 = n_a_e;
        end else begin
            n_t4 = (n_b_e < n_a_e) ? n_b_e : n_a_e;
        end
        n_sf = r_present && (r_flags[0] || r_flags[2]);
        n_ef = r_present && (r_flags[1] || r_flags[3]);
    end

    logic                          r_s1_v;
    logic signed [TW-1:0]          r_s1_t, r_s1_t1, r_s1_t4;
    logic signed [SAMPLE_BITS-1:0] r_s1_l, r_s1_r;
    logic                          r_s1_sf, r_s1_ef, r_s1_pres;

    // stage 2: ramp ends and empty envelope
    logic signed [TW-1:0] n_t2, n_t3;
    logic                 n_never;

    always_comb begin
        n_t2    = clamp_bp(clamp_bp(r_s1_t1) + w_len);
        n_t3    = clamp_bp(clamp_bp(r_s1_t4) - w_len);
        n_never = r_s1_sf && r_s1_ef && (r_s1_t1 >= r_s1_t4);
    end

    logic                          r_s2_v;
    logic signed [TW-1:0]          r_s2_t, r_s2_t1, r_s2_t2, r_s2_t3, r_s2_t4;
    logic signed [SAMPLE_BITS-1:0] r_s2_l, r_s2_r;
    logic                          r_s2_sf, r_s2_ef, r_s2_block;

    // stage 3: overlap test and midpoint sum
    logic signed [TW:0] n_sum;
    logic               n_ovl;

    always_comb begin
        n_sum = {r_s2_t2[TW-1], r_s2_t2} + {r_s2_t3[TW-1], r_s2_t3};
        n_ovl = r_s2_sf && r_s2_ef && (r_s2_t2 >= r_s2_t3);
    end

    logic                          r_s3_v;
    logic signed [TW-1:0]          r_s3_t, r_s3_t1, r_s3_t2, r_s3_t3, r_s3_t4;
    logic signed [TW:0]            r_s3_sum;
    logic signed [SAMPLE_BITS-1:0] r_s3_l, r_s3_r;
    logic                          r_s3_sf, r_s3_ef, r_s3_block, r_s3_ovl;

    // stage 4: midpoint rounded toward zero
    logic signed [TW:0]   w_sum_adj;
    logic signed [TW-1:0] n_mid_t2, n_mid_t3;

    always_comb begin
        w_sum_adj = r_s3_sum + $signed({{TW{1'b0}}, r_s3_sum[TW]});
        if (r_s3_ovl) begin
            n_mid_t2 = w_sum_adj[TW:1];
            n_mid_t3 = w_sum_adj[TW:1];
        end else begin
            n_mid_t2 = r_s3_t2;
            n_mid_t3 = r_s3_t3;
        end
    end

    logic                          r_s4_v;
    logic signed [TW-1:0]          r_s4_t, r_s4_t1, r_s4_t2, r_s4_t3, r_s4_t4;
    logic signed [SAMPLE_BITS-1:0] r_s4_l, r_s4_r;
    logic                          r_s4_sf, r_s4_ef, r_s4_block;

    // stage 5: region and ramp numerator
    logic [REGION_BITS-1:0] n_region;
    logic signed [TW-1:0]   w_diff_up, w_diff_dn;
    logic [NUM_W-1:0]       n_num;

    always_comb begin
        w_diff_up = r_s4_t - r_s4_t1;
        w_diff_dn = r_s4_t4 - r_s4_t;
        if (r_s4_block) begin
            n_region = REGION_BEFORE;
        end else if (r_s4_sf && (r_s4_t < r_s4_t1)) begin
            n_region = REGION_BEFORE;
        end else if (r_s4_sf && (r_s4_t < r_s4_t2)) begin
            n_region = REGION_UP;
        end else if (!r_s4_ef || (r_s4_t < r_s4_t3)) begin
            n_region = REGION_UNITY;
        end else if (r_s4_t < r_s4_t4) begin
            n_region = REGION_DOWN;
        end else begin
            n_region = REGION_AFTER;
        end
        if (n_region == REGION_UP) begin
            n_num = w_diff_up[NUM_W-1:0];
        end else begin
            n_num = w_diff_dn[NUM_W-1:0];
        end
    end

    logic             r_s5_v;
    logic [NUM_W-1:0] r_s5_num;
    t_side            r_s5_side;

    logic                 w_div_v;
    logic [GAIN_BITS-1:0] w_quot;
    t_side                w_div_side;

    lfeg_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_s5_v),
        .i_num   (r_s5_num),
        .i_len   (r_fade_length),
        .i_side  (r_s5_side),
        .o_valid (w_div_v),
        .o_quot  (w_quot),
        .o_side  (w_div_side)
    );

    // gain select
    logic [GAIN_BITS-1:0] n_gain;

    always_comb begin
        case (w_div_side.region)
            REGION_UP, REGION_DOWN: begin
                n_gain = (w_quot > GAIN_UNITY) ? GAIN_UNITY : w_quot;
            end
            REGION_UNITY: n_gain = GAIN_UNITY;
            default:      n_gain = '0;
        endcase
    end

    logic                 r_s6_v;
    logic [GAIN_BITS-1:0] r_s6_gain;
    t_side                r_s6_side;

    logic                     r_s7_v;
    logic signed [PROD_W-1:0] r_s7_pl, r_s7_pr;
    logic [GAIN_BITS-1:0]     r_s7_gain;
    logic [REGION_BITS-1:0]   r_s7_region;

    logic signed [GAIN_BITS:0] w_gain_s;
    assign w_gain_s = $signed({1'b0, r_s6_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_s7_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_s6_v  <= w_div_v;
            r_s7_v  <= r_s6_v;
            r_out_v <= r_s7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_t    <= ext_time(i_sample_time);
            r_s1_l    <= i_left_sample;
            r_s1_r    <= i_right_sample;
            r_s1_t1   <= n_t1;
            r_s1_t4   <= n_t4;
            r_s1_sf   <= n_sf;
            r_s1_ef   <= n_ef;
            r_s1_pres <= r_present;

            r_s2_t     <= r_s1_t;
            r_s2_l     <= r_s1_l;
            r_s2_r     <= r_s1_r;
            r_s2_t1    <= r_s1_t1;
            r_s2_t2    <= n_t2;
            r_s2_t3    <= n_t3;
            r_s2_t4    <= r_s1_t4;
            r_s2_sf    <= r_s1_sf;
            r_s2_ef    <= r_s1_ef;
            r_s2_block <= !r_s1_pres || n_never;

            r_s3_t     <= r_s2_t;
            r_s3_l     <= r_s2_l;
            r_s3_r     <= r_s2_r;
            r_s3_t1    <= r_s2_t1;
            r_s3_t2    <= r_s2_t2;
            r_s3_t3    <= r_s2_t3;
            r_s3_t4    <= r_s2_t4;
            r_s3_sum   <= n_sum;
            r_s3_ovl   <= n_ovl && !r_s2_block;
            r_s3_sf    <= r_s2_sf;
            r_s3_ef    <= r_s2_ef;
            r_s3_block <= r_s2_block;

            r_s4_t     <= r_s3_t;
            r_s4_l     <= r_s3_l;
            r_s4_r     <= r_s3_r;
            r_s4_t1    <= r_s3_t1;
            r_s4_t2    <= n_mid_t2;
            r_s4_t3    <= n_mid_t3;
            r_s4_t4    <= r_s3_t4;
            r_s4_sf    <= r_s3_sf;
            r_s4_ef    <= r_s3_ef;
            r_s4_block <= r_s3_block;

            r_s5_num          <= n_num;
            r_s5_side.region  <= n_region;
            r_s5_side.left    <= r_s4_l;
            r_s5_side.right   <= r_s4_r;

            r_s6_gain <= n_gain;
            r_s6_side <= w_div_side;

            r_s7_pl     <= r_s6_side.left * w_gain_s;
            r_s7_pr     <= r_s6_side.right * w_gain_s;
            r_s7_gain   <= r_s6_gain;
            r_s7_region <= r_s6_side.region;

            // floor shift of the products
            o_left_out  <= r_s7_pl[SAMPLE_BITS+Q_BITS-1:Q_BITS];
            o_right_out <= r_s7_pr[SAMPLE_BITS+Q_BITS-1:Q_BITS];
            o_gain      <= r_s7_gain;
            o_region    <= r_s7_region;
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fade envelope gain block. A directed table of
// frames covers reset, unity, ramp edges, reversed and overlapping fades,
// zero and full ramp lengths and time rails, followed by random phases with
// fresh register settings, random sender gaps and receiver stalls. Every
// output transfer is compared field by field with the expected frame of a
// typed table row or else with a cycle-free envelope predictor in the bench.
// ----------------------------------------------------------------------------
module tb;
    import lfeg_pkg::*;

    localparam int RANDOM_FRAMES  = 1600;
    localparam int QUIET_FRAMES   = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_PRINTS     = 40;

    localparam logic signed [TIME_BITS-1:0] T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
    localparam logic signed [TIME_BITS-1:0] T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [LEN_BITS-1:0] L_MAX = '1;

    localparam longint NEG_INF  = {1'b1, 63'd0};
    localparam longint POS_INF  = {1'b0, {63{1'b1}}};
    localparam longint BP_LIMIT = longint'(1) << 62;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [REGION_BITS-1:0]        region;
        logic [GAIN_BITS-1:0]          gain;
    } gain_frame_t;

    typedef struct {
        logic signed [TIME_BITS-1:0] fade_start;
        logic signed [TIME_BITS-1:0] fade_end;
        logic signed [TIME_BITS-1:0] source_start;
        logic signed [TIME_BITS-1:0] source_end;
        logic [LEN_BITS-1:0]         fade_length;
        logic [FLAG_BITS-1:0]        flags;
        logic                        present;
    } fade_profile_t;

    typedef struct {
        int                            prof;
        logic signed [TIME_BITS-1:0]   t;
        logic signed [SAMPLE_BITS-1:0] l;
        logic signed [SAMPLE_BITS-1:0] r;
        bit                            typed;
        gain_frame_t                   want;
    } stim_row_t;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]         i_cfg_addr = '0;
    logic [CFG_W-1:0]              i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [TIME_BITS-1:0]   i_sample_time = '0;
    logic signed [SAMPLE_BITS-1:0] i_left_sample = '0;
    logic signed [SAMPLE_BITS-1:0] i_right_sample = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_left_out;
    logic signed [SAMPLE_BITS-1:0] o_right_out;
    logic [REGION_BITS-1:0]        o_region;
    logic [GAIN_BITS-1:0]          o_gain;

    // register shadow
    logic signed [TIME_BITS-1:0] cur_fade_start = '0;
    logic signed [TIME_BITS-1:0] cur_fade_end = '0;
    logic signed [TIME_BITS-1:0] cur_source_start = '0;
    logic signed [TIME_BITS-1:0] cur_source_end = '0;
    logic [LEN_BITS-1:0]         cur_len = '0;
    logic [FLAG_BITS-1:0]        cur_flags = '0;
    logic                        cur_present = 1'b0;

    gain_frame_t   pending_frames[$];
    fade_profile_t profiles[$];
    stim_row_t     stim_rows[$];

    int mismatch_count = 0;
    int out_idx = 0;
    int quiet_cycles = 0;
    int stall_pct = 0;
    int stall_left = 0;

    linear_fade_envelope_gain uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample_time  (i_sample_time),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_region       (o_region),
        .o_gain         (o_gain)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint sat_bp(input longint a);
        if (a > BP_LIMIT) begin
            return BP_LIMIT;
        end
        if (a < -BP_LIMIT) begin
            return -BP_LIMIT;
        end
        return a;
    endfunction

    function automatic gain_frame_t predict_envelope(
        input logic signed [TIME_BITS-1:0]   t_in,
        input logic signed [SAMPLE_BITS-1:0] l_in,
        input logic signed [SAMPLE_BITS-1:0] r_in
    );
        longint t, len, half, t1, t2, t3, t4, fade_edge, src_edge, g;
        gain_frame_t f;
        t = t_in;
        len = longint'(cur_len);
        half = len / 2;
        t1 = NEG_INF;
        t2 = NEG_INF;
        t3 = POS_INF;
        t4 = POS_INF;
        g = 0;
        f.region = REGION_BEFORE;
        if (cur_present) begin
            if (cur_flags[0] || cur_flags[2]) begin
                fade_edge = sat_bp(sat_bp(cur_fade_start) - half);
                src_edge = sat_bp(cur_source_start);
                if (!cur_flags[0]) begin
                    t1 = src_edge;
                end else if (!cur_flags[2]) begin
                    t1 = fade_edge;
                end else begin
                    t1 = (src_edge > fade_edge) ? src_edge : fade_edge;
                end
                t2 = sat_bp(t1 + len);
            end
            if (cur_flags[1] || cur_flags[3]) begin
                fade_edge = sat_bp(sat_bp(cur_fade_end) + half);
                src_edge = sat_bp(cur_source_end);
                if (!cur_flags[1]) begin
                    t4 = src_edge;
                end else if (!cur_flags[3]) begin
                    t4 = fade_edge;
                end else begin
                    t4 = (src_edge < fade_edge) ? src_edge : fade_edge;
                end
                t3 = sat_bp(t4 - len);
            end
            if (t1 != NEG_INF && t4 != POS_INF) begin
                if (t1 >= t4) begin
                    // never faded in
                    t1 = POS_INF;
                    t2 = POS_INF;
                    t3 = NEG_INF;
                    t4 = NEG_INF;
                end else if (t2 >= t3) begin
                    t2 = (t2 + t3) / 2;
                    t3 = t2;
                end
            end
            if (t < t1) begin
                f.region = REGION_BEFORE;
            end else if (t < t2) begin
                f.region = REGION_UP;
                if (len > 0) begin
                    g = ((t - t1) * longint'(GAIN_UNITY)) / len;
                end
            end else if (t < t3) begin
                f.region = REGION_UNITY;
                g = longint'(GAIN_UNITY);
            end else if (t < t4) begin
                f.region = REGION_DOWN;
                if (len > 0) begin
                    g = ((t4 - t) * longint'(GAIN_UNITY)) / len;
                end
            end else begin
                f.region = REGION_AFTER;
            end
            if (g > longint'(GAIN_UNITY)) begin
                g = longint'(GAIN_UNITY);
            end
        end
        f.gain = GAIN_BITS'(g);
        f.left = SAMPLE_BITS'((longint'(l_in) * g) >>> Q_BITS);
        f.right = SAMPLE_BITS'((longint'(r_in) * g) >>> Q_BITS);
        return f;
    endfunction

    function automatic logic signed [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom, $urandom});
    endfunction

    function automatic longint rand_offset(input int span);
        return longint'($urandom_range(2 * span)) - longint'(span);
    endfunction

    function automatic logic signed [TIME_BITS-1:0] rail_time();
        case ($urandom_range(2))
            0: return T_MIN;
            1: return T_MAX;
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(15))
            0: return S_MAX;
            1: return S_MIN;
            2: return -1;
            3: return 0;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic logic signed [TIME_BITS-1:0] pick_time();
        int span;
        span = int'(cur_len) + 64;
        case ($urandom_range(7))
            0: return rand_time();
            1, 2: return cur_fade_start + TIME_BITS'(rand_offset(span));
            3, 4: return cur_fade_end + TIME_BITS'(rand_offset(span));
            5: return cur_source_start + TIME_BITS'(rand_offset(span));
            6: return cur_source_end + TIME_BITS'(rand_offset(span));
            default: return TIME_BITS'(rand_offset(span));
        endcase
    endfunction

    function automatic fade_profile_t rand_profile();
        fade_profile_t p;
        logic signed [TIME_BITS-1:0] base;
        int kind;
        kind = $urandom_range(9);
        if (kind == 0) begin
            p.fade_start = rand_time();
            p.fade_end = rand_time();
            p.source_start = rand_time();
            p.source_end = rand_time();
            p.fade_length = LEN_BITS'($urandom);
            p.flags = FLAG_BITS'($urandom);
            p.present = 1'($urandom);
        end else if (kind == 1) begin
            p.fade_start = rail_time();
            p.fade_end = rail_time();
            p.source_start = rail_time();
            p.source_end = rail_time();
            case ($urandom_range(2))
                0: p.fade_length = '0;
                1: p.fade_length = LEN_BITS'(1);
                default: p.fade_length = L_MAX;
            endcase
            p.flags = FLAG_BITS'($urandom);
            p.present = 1'b1;
        end else begin
            base = ($urandom_range(3) == 0) ? rand_time() : TIME_BITS'(rand_offset(100000));
            case ($urandom_range(15))
                0: p.fade_length = LEN_BITS'($urandom);
                1, 2, 3: p.fade_length = LEN_BITS'($urandom_range(4));
                4, 5, 6, 7: p.fade_length = LEN_BITS'($urandom_range(5000));
                default: p.fade_length = LEN_BITS'($urandom_range(300));
            endcase
            p.fade_start = base + TIME_BITS'(rand_offset(2000));
            p.fade_end = p.fade_start + TIME_BITS'(rand_offset(3000) + 1000);
            p.source_start = base + TIME_BITS'(rand_offset(2000));
            p.source_end = p.fade_end + TIME_BITS'(rand_offset(1500));
            p.flags = ($urandom_range(3) == 0) ? 4'b1111 : FLAG_BITS'($urandom);
            p.present = ($urandom_range(15) != 0);
        end
        return p;
    endfunction

    task automatic add_profile(
        input logic signed [TIME_BITS-1:0] fs,
        input logic signed [TIME_BITS-1:0] fe,
        input logic signed [TIME_BITS-1:0] ss,
        input logic signed [TIME_BITS-1:0] se,
        input logic [LEN_BITS-1:0]         len,
        input logic [FLAG_BITS-1:0]        flags,
        input logic                        present
    );
        fade_profile_t p;
        p.fade_start = fs;
        p.fade_end = fe;
        p.source_start = ss;
        p.source_end = se;
        p.fade_length = len;
        p.flags = flags;
        p.present = present;
        profiles.push_back(p);
    endtask

    task automatic add_row(
        input int                            prof,
        input logic signed [TIME_BITS-1:0]   t,
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r,
        input bit                            typed,
        input logic signed [SAMPLE_BITS-1:0] want_l,
        input logic signed [SAMPLE_BITS-1:0] want_r,
        input logic [REGION_BITS-1:0]        want_region,
        input logic [GAIN_BITS-1:0]          want_gain
    );
        stim_row_t row;
        row.prof = prof;
        row.t = t;
        row.l = l;
        row.r = r;
        row.typed = typed;
        row.want.left = want_l;
        row.want.right = want_r;
        row.want.region = want_region;
        row.want.gain = want_gain;
        stim_rows.push_back(row);
    endtask

    // pipeline must be empty before this is called
    task automatic load_profile(input fade_profile_t p);
        logic [CFG_W-1:0]      data;
        logic [CFG_ADDR_W-1:0] idx;
        for (int k = 0; k <= int'(CFG_SOURCE_PRESENT); k++) begin
            idx = CFG_ADDR_W'(k);
            // junk above the register width must be dropped
            data = ($urandom_range(3) == 0) ? CFG_W'({$urandom, $urandom}) : '0;
            case (idx)
                CFG_FADE_START: begin
                    data = p.fade_start;
                    cur_fade_start = p.fade_start;
                end
                CFG_FADE_END: begin
                    data = p.fade_end;
                    cur_fade_end = p.fade_end;
                end
                CFG_SOURCE_START: begin
                    data = p.source_start;
                    cur_source_start = p.source_start;
                end
                CFG_SOURCE_END: begin
                    data = p.source_end;
                    cur_source_end = p.source_end;
                end
                CFG_FADE_LENGTH: begin
                    data[LEN_BITS-1:0] = p.fade_length;
                    cur_len = p.fade_length;
                end
                CFG_DEFINED_FLAGS: begin
                    data[FLAG_BITS-1:0] = p.flags;
                    cur_flags = p.flags;
                end
                CFG_SOURCE_PRESENT: begin
                    data[0] = p.present;
                    cur_present = p.present;
                end
                default: ;
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_addr <= idx;
            i_cfg_data <= data;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_frame(
        input logic signed [TIME_BITS-1:0]   t,
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r,
        input int                            gap,
        input bit                            typed,
        input gain_frame_t                   want
    );
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_time <= t;
        i_left_sample <= l;
        i_right_sample <= r;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_frames.push_back(typed ? want : predict_envelope(t, l, r));
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (int'($urandom_range(99)) < stall_pct) begin
            i_stall <= 1'b1;
            stall_left <= int'($urandom_range(16, 1)) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_out
        gain_frame_t want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("frame %0d with no transfer pending", out_idx));
            end else begin
                want = pending_frames.pop_front();
                if (o_left_out !== want.left) begin
                    report_mismatch($sformatf("frame %0d left_out got %0d want %0d",
                        out_idx, o_left_out, want.left));
                end
                if (o_right_out !== want.right) begin
                    report_mismatch($sformatf("frame %0d right_out got %0d want %0d",
                        out_idx, o_right_out, want.right));
                end
                if (o_region !== want.region) begin
                    report_mismatch($sformatf("frame %0d region got %0d want %0d",
                        out_idx, o_region, want.region));
                end
                if (o_gain !== want.gain) begin
                    report_mismatch($sformatf("frame %0d gain got %0d want %0d",
                        out_idx, o_gain, want.gain));
                end
            end
            out_idx++;
        end
    end

    // no transfer on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_stall == 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          cur_prof;
        int          sent;
        int          n;
        int          gap;
        int          mode;
        bit          quiet;
        gain_frame_t none;

        none = '{default: '0};
        cur_prof = 0;

        add_profile(0, 0, 0, 0, 0, 4'b0000, 1'b0);
        add_profile(0, 0, 0, 0, 0, 4'b0000, 1'b1);
        add_profile(1000, 5000, 0, 0, 200, 4'b0011, 1'b1);
        add_profile(1000, 5000, 950, 5050, 200, 4'b1111, 1'b1);
        add_profile(5000, 1000, 0, 0, 200, 4'b0011, 1'b1);
        add_profile(1000, 1100, 0, 0, 400, 4'b0011, 1'b1);
        add_profile(100, 200, 0, 0, 0, 4'b0011, 1'b1);
        add_profile(48'sh7FFF_0000_1234, -5, -50, 50, L_MAX, 4'b1100, 1'b1);
        add_profile(T_MAX, T_MIN, T_MIN, T_MAX, L_MAX, 4'b0101, 1'b1);
        add_profile(T_MAX, T_MIN, T_MIN, T_MAX, L_MAX, 4'b1010, 1'b1);

        // straight out of reset: no source
        add_row(0, 0, S_MAX, S_MIN, 1, 0, 0, REGION_BEFORE, 0);
        // nothing defined: unity everywhere
        add_row(1, T_MAX, S_MAX, S_MIN, 1, S_MAX, S_MIN, REGION_UNITY, GAIN_UNITY);
        add_row(1, T_MIN, -1, 1, 1, -1, 1, REGION_UNITY, GAIN_UNITY);
        // plain fade in and out
        add_row(2, 899, 1000, -1000, 1, 0, 0, REGION_BEFORE, 0);
        add_row(2, 900, S_MAX, S_MIN, 1, 0, 0, REGION_UP, 0);
        add_row(2, 1000, S_MIN, S_MAX, 0, 0, 0, REGION_BEFORE, 0);
        add_row(2, 1099, -3, 3, 0, 0, 0, REGION_BEFORE, 0);
        add_row(2, 1100, 5, -5, 1, 5, -5, REGION_UNITY, GAIN_UNITY);
        add_row(2, 4950, -7, 77, 0, 0, 0, REGION_BEFORE, 0);
        add_row(2, 5100, S_MAX, S_MIN, 1, 0, 0, REGION_AFTER, 0);
        // source limits cut into the fades
        add_row(3, 949, 4096, -4096, 0, 0, 0, REGION_BEFORE, 0);
        add_row(3, 1050, -8191, 8191, 0, 0, 0, REGION_BEFORE, 0);
        add_row(3, 5049, S_MIN, S_MAX, 0, 0, 0, REGION_BEFORE, 0);
        // fade-out ahead of fade-in stays silent
        add_row(4, 3000, 100, 100, 1, 0, 0, REGION_BEFORE, 0);
        add_row(4, T_MIN, S_MAX, S_MAX, 1, 0, 0, REGION_BEFORE, 0);
        // ramps overlap and meet at the midpoint
        add_row(5, 900, -12345, 12345, 0, 0, 0, REGION_BEFORE, 0);
        add_row(5, 1050, S_MAX, S_MIN, 0, 0, 0, REGION_BEFORE, 0);
        add_row(5, 1200, -1, -2, 0, 0, 0, REGION_BEFORE, 0);
        // zero ramp length
        add_row(6, 99, 9, 9, 1, 0, 0, REGION_BEFORE, 0);
        add_row(6, 100, 9, -9, 1, 9, -9, REGION_UNITY, GAIN_UNITY);
        add_row(6, 200, 1, 1, 1, 0, 0, REGION_AFTER, 0);
        // source limits only, full ramp length, fade values ignored
        add_row(7, 0, S_MAX, S_MIN, 0, 0, 0, REGION_BEFORE, 0);
        add_row(7, -50, -100, 100, 0, 0, 0, REGION_BEFORE, 0);
        // time rails
        add_row(8, T_MAX, S_MAX, S_MIN, 0, 0, 0, REGION_BEFORE, 0);
        add_row(9, T_MIN, S_MIN, S_MAX, 0, 0, 0, REGION_BEFORE, 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].prof != cur_prof) begin
                wait_drained();
                load_profile(profiles[stim_rows[i].prof]);
                cur_prof = stim_rows[i].prof;
            end
            send_frame(stim_rows[i].t, stim_rows[i].l, stim_rows[i].r, 0,
                stim_rows[i].typed, stim_rows[i].want);
        end

        sent = 0;
        while (sent < RANDOM_FRAMES) begin
            quiet = (sent >= RANDOM_FRAMES - QUIET_FRAMES);
            mode = quiet ? 0 : int'($urandom_range(2));
            stall_pct = (mode == 0) ? 0 : (mode == 1) ? 10 : 40;
            wait_drained();
            load_profile(rand_profile());
            n = $urandom_range(90, 30);
            repeat (n) begin
                gap = 0;
                if (mode != 0 && int'($urandom_range(99)) < stall_pct) begin
                    gap = $urandom_range(16, 1);
                end
                send_frame(pick_time(), rand_sample(), rand_sample(), gap, 0, none);
                sent++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
